// ----- hw/rtl/orb_pkg.sv -----
`timescale 1ns / 1ps

package orb_pkg;

	// Ring geometry.
	localparam int unsigned RING_DEPTH = 1024;
	localparam int unsigned ADDR_W     = $clog2(RING_DEPTH);
	localparam int unsigned FILL_W     = $clog2(RING_DEPTH + 1);

	// Field widths on the stream ports.
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned BURST_W   = 7;
	localparam int unsigned HELD_W    = 11;
	localparam int unsigned CTR_W     = 64;
	localparam int unsigned FUNC_W    = 2;
	localparam int unsigned MAX_BURST = 64;

	// Packed stream widths, rounded up to whole bytes.
	localparam int unsigned IN_BITS    = BYTE_W + BURST_W;
	localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS   = BYTE_W + HELD_W + 2 * CTR_W;
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_STATS = 2'd3;

endpackage

// ----- hw/rtl/orb_ram.sv -----
`timescale 1ns / 1ps

module orb_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned ADDR_W = 10,
	parameter int unsigned DEPTH  = 1024
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while no read is enabled.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/overwrite_oldest_byte_ring_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tdata: in_byte[7:0], read_max[14:8], zero[15]; tuser: func[1:0]
// m_axis    out        tdata: out_byte[7:0], held_count[18:8], rx_total[82:19],
//                             drop_total[146:83], zero[151:147];
//                      tuser: has_data[0]; tlast: last
//
// Push and flush need no output slot. A stats query or an empty read puts its result
// in the output register once that register is free. A read of n bytes streams one byte
// a cycle, while the output does not stall, out of the single read port of the byte RAM.
// The input side takes a new item once every result of a read or stats item is loaded.
// Reset clears the pointers, fill level and counters; the byte RAM is not cleared.
// Output stalls only pause the read burst; no byte is dropped or repeated.
module overwrite_oldest_byte_ring_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [orb_pkg::IN_DATA_W-1:0]         s_axis_tdata,   // in_byte, read_max
	input  logic [orb_pkg::FUNC_W-1:0]            s_axis_tuser,   // func
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [orb_pkg::OUT_DATA_W-1:0]        m_axis_tdata,   // out_byte, held_count,
	                                                              // rx_total, drop_total
	output logic [0:0]                            m_axis_tuser,   // has_data
	output logic                                  m_axis_tlast
);

	localparam logic [orb_pkg::ADDR_W-1:0] LAST_ADDR =
		orb_pkg::ADDR_W'(orb_pkg::RING_DEPTH - 1);

	// Input field views.
	logic [orb_pkg::BYTE_W-1:0]  in_byte;
	logic [orb_pkg::BURST_W-1:0] read_max;
	logic [orb_pkg::FUNC_W-1:0]  func;

	assign in_byte  = s_axis_tdata[orb_pkg::BYTE_W-1:0];
	assign read_max = s_axis_tdata[orb_pkg::BYTE_W +: orb_pkg::BURST_W];
	assign func     = s_axis_tuser;

	// Control and status registers.
	logic [orb_pkg::ADDR_W-1:0]  head_q;
	logic [orb_pkg::FILL_W-1:0]  fill_q;
	logic [orb_pkg::CTR_W-1:0]   rx_q;
	logic [orb_pkg::CTR_W-1:0]   drop_q;
	logic                        busy_q;
	logic                        empty_q;
	logic [orb_pkg::BURST_W-1:0] issue_left_q;
	logic [orb_pkg::BURST_W-1:0] load_left_q;
	logic [orb_pkg::ADDR_W-1:0]  rd_addr_q;
	logic                        pend_s1;

	// Output register.
	logic                        out_valid_q;
	logic [orb_pkg::BYTE_W-1:0]  out_byte_q;
	logic                        out_has_q;
	logic                        out_last_q;
	logic [orb_pkg::HELD_W-1:0]  out_held_q;
	logic [orb_pkg::CTR_W-1:0]   out_rx_q;
	logic [orb_pkg::CTR_W-1:0]   out_drop_q;

	logic                        in_xfer;
	logic                        out_slot;
	logic                        load;
	logic                        issue;
	logic [orb_pkg::BYTE_W-1:0]  rd_data;
	logic [orb_pkg::BURST_W-1:0] want_sat;
	logic [orb_pkg::BURST_W-1:0] burst_len;
	logic [orb_pkg::FILL_W:0]    tail_wide;
	logic [orb_pkg::ADDR_W-1:0]  tail;
	logic [orb_pkg::FILL_W-1:0]  fill_dec;

	assign s_axis_tready = !busy_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Burst length: the request saturated to the burst limit, then bounded by the fill.
	assign want_sat  = (read_max > orb_pkg::BURST_W'(orb_pkg::MAX_BURST)) ?
		orb_pkg::BURST_W'(orb_pkg::MAX_BURST) : read_max;
	assign burst_len = (fill_q < orb_pkg::FILL_W'(want_sat)) ?
		orb_pkg::BURST_W'(fill_q) : want_sat;

	// Oldest entry sits fill bytes behind the head, modulo the ring depth.
	always_comb begin
		if (orb_pkg::FILL_W'(head_q) >= fill_q) begin
			tail_wide = (orb_pkg::FILL_W + 1)'(head_q) - (orb_pkg::FILL_W + 1)'(fill_q);
		end else begin
			tail_wide = (orb_pkg::FILL_W + 1)'(head_q)
				+ (orb_pkg::FILL_W + 1)'(orb_pkg::RING_DEPTH)
				- (orb_pkg::FILL_W + 1)'(fill_q);
		end
	end
	assign tail = tail_wide[orb_pkg::ADDR_W-1:0];

	// Output register is free or emptying this cycle.
	assign out_slot = !out_valid_q || m_axis_tready;
	assign load     = busy_q && out_slot && (empty_q || pend_s1);
	// A read is issued only when the RAM output holds no unloaded byte or that byte is being loaded.
	assign issue    = busy_q && !empty_q && (issue_left_q != '0) && (!pend_s1 || load);
	assign fill_dec = fill_q - orb_pkg::FILL_W'(1);

	orb_ram #(
		.DATA_W(orb_pkg::BYTE_W),
		.ADDR_W(orb_pkg::ADDR_W),
		.DEPTH (orb_pkg::RING_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (in_xfer && (func == orb_pkg::FUNC_PUSH)),
		.wr_addr(head_q),
		.wr_data(in_byte),
		.rd_en  (issue),
		.rd_addr(rd_addr_q),
		.rd_data(rd_data)
	);

	// Ring pointers, fill level and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			rx_q   <= '0;
			drop_q <= '0;
		end else if (in_xfer) begin
			case (func)
				orb_pkg::FUNC_PUSH: begin
					head_q <= (head_q == LAST_ADDR) ? '0 : head_q + orb_pkg::ADDR_W'(1);
					rx_q   <= rx_q + orb_pkg::CTR_W'(1);
					if (fill_q < orb_pkg::FILL_W'(orb_pkg::RING_DEPTH)) begin
						fill_q <= fill_q + orb_pkg::FILL_W'(1);
					end else begin
						drop_q <= drop_q + orb_pkg::CTR_W'(1);
					end
				end
				orb_pkg::FUNC_FLUSH: begin
					head_q <= '0;
					fill_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (load && !empty_q) begin
			fill_q <= fill_dec;
		end
	end

	// Burst sequencer: issue counter, load counter and read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			empty_q      <= 1'b0;
			issue_left_q <= '0;
			load_left_q  <= '0;
			rd_addr_q    <= '0;
			pend_s1      <= 1'b0;
		end else if (in_xfer) begin
			if (func == orb_pkg::FUNC_READ && burst_len != '0) begin
				busy_q       <= 1'b1;
				empty_q      <= 1'b0;
				issue_left_q <= burst_len;
				load_left_q  <= burst_len;
				rd_addr_q    <= tail;
			end else if (func == orb_pkg::FUNC_READ || func == orb_pkg::FUNC_STATS) begin
				busy_q       <= 1'b1;
				empty_q      <= 1'b1;
				issue_left_q <= '0;
				load_left_q  <= orb_pkg::BURST_W'(1);
			end
		end else begin
			if (issue) begin
				issue_left_q <= issue_left_q - orb_pkg::BURST_W'(1);
				rd_addr_q    <= (rd_addr_q == LAST_ADDR) ? '0 : rd_addr_q + orb_pkg::ADDR_W'(1);
			end
			if (issue) begin
				pend_s1 <= 1'b1;
			end else if (load) begin
				pend_s1 <= 1'b0;
			end
			if (load) begin
				load_left_q <= load_left_q - orb_pkg::BURST_W'(1);
				if (load_left_q == orb_pkg::BURST_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; counters are stable for the whole burst.
	always_ff @(posedge clk) begin
		if (load) begin
			out_last_q <= (load_left_q == orb_pkg::BURST_W'(1));
			out_rx_q   <= rx_q;
			out_drop_q <= drop_q;
			if (empty_q) begin
				out_byte_q <= '0;
				out_has_q  <= 1'b0;
				out_held_q <= orb_pkg::HELD_W'(fill_q);
			end else begin
				out_byte_q <= rd_data;
				out_has_q  <= 1'b1;
				out_held_q <= orb_pkg::HELD_W'(fill_dec);
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_has_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = orb_pkg::OUT_DATA_W'({out_drop_q, out_rx_q, out_held_q, out_byte_q});

	// The fill level never exceeds the ring depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= orb_pkg::FILL_W'(orb_pkg::RING_DEPTH))
		else $error("fill level above ring depth");

	// No RAM data is outstanding once the sequencer is idle.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !pend_s1)
		else $error("read data pending while idle");

	// Reads issued never run ahead of the results still to load.
	a_issue_le_load: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (issue_left_q <= load_left_q))
		else $error("issue count ahead of load count");

	// A result without a byte is always the only and final one.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
		else $error("empty result without last");

	// A byte loaded into the output reduces the fill level by one.
	a_fill_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !empty_q) |=> (fill_q == $past(fill_dec)))
		else $error("fill level not reduced on delivered byte");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES  = 250;

	// Bit offsets of the result fields inside m_axis_tdata.
	localparam int unsigned HELD_LO = orb_pkg::BYTE_W;
	localparam int unsigned RX_LO   = HELD_LO + orb_pkg::HELD_W;
	localparam int unsigned DROP_LO = RX_LO + orb_pkg::CTR_W;

	typedef struct {
		logic [orb_pkg::BYTE_W-1:0] out_byte;
		logic                       has_data;
		logic                       last;
		logic [orb_pkg::HELD_W-1:0] held_count;
		logic [orb_pkg::CTR_W-1:0]  rx_total;
		logic [orb_pkg::CTR_W-1:0]  drop_total;
	} ring_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [orb_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic [orb_pkg::FUNC_W-1:0]     s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [orb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]                     m_axis_tuser;
	logic                           m_axis_tlast;

	// Shadow copy of the ring, updated on every accepted input transfer.
	logic [orb_pkg::BYTE_W-1:0] ring_mem [orb_pkg::RING_DEPTH];
	logic [orb_pkg::ADDR_W-1:0] ring_head;
	logic [orb_pkg::FILL_W-1:0] ring_fill;
	logic [orb_pkg::CTR_W-1:0]  rx_count;
	logic [orb_pkg::CTR_W-1:0]  drop_count;
	ring_result_t               pending_results [$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_req;
	int unsigned hold_seen;
	int unsigned stall_left;
	int unsigned cycle_count;
	int unsigned error_count;
	int unsigned results_checked;
	int unsigned pushes_sent;
	int unsigned reads_sent;
	int unsigned flushes_sent;
	int unsigned stats_sent;

	overwrite_oldest_byte_ring_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb failed");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Work out the results one input transfer causes and queue them.
	function automatic void predict_ring(input logic [orb_pkg::FUNC_W-1:0] func,
			input logic [orb_pkg::BYTE_W-1:0] data, input logic [orb_pkg::BURST_W-1:0] req);
		int unsigned                n;
		logic [orb_pkg::ADDR_W-1:0] rd_ptr;
		ring_result_t               res;
		case (func)
			orb_pkg::FUNC_PUSH: begin
				ring_mem[ring_head] = data;
				ring_head = ring_head + 1'b1;
				if (ring_fill < orb_pkg::RING_DEPTH)
					ring_fill = ring_fill + 1'b1;
				else
					drop_count = drop_count + 1'b1;
				rx_count = rx_count + 1'b1;
			end
			orb_pkg::FUNC_FLUSH: begin
				ring_fill = '0;
				ring_head = '0;
			end
			orb_pkg::FUNC_STATS: begin
				res = '{'0, 1'b0, 1'b1, ring_fill, rx_count, drop_count};
				pending_results.push_back(res);
			end
			default: begin
				n = (req > orb_pkg::MAX_BURST) ? orb_pkg::MAX_BURST : req;
				if (n > ring_fill)
					n = ring_fill;
				if (n == 0) begin
					res = '{'0, 1'b0, 1'b1, ring_fill, rx_count, drop_count};
					pending_results.push_back(res);
				end else begin
					// The oldest byte sits fill_count entries behind the head.
					rd_ptr = ring_head - ring_fill[orb_pkg::ADDR_W-1:0];
					for (int i = 0; i < n; i++) begin
						ring_fill = ring_fill - 1'b1;
						res = '{ring_mem[rd_ptr], 1'b1, (i == n - 1), ring_fill,
							rx_count, drop_count};
						pending_results.push_back(res);
						rd_ptr = rd_ptr + 1'b1;
					end
				end
			end
		endcase
	endfunction

	// Offer one item, wait for its transfer, then predict its results.
	task automatic send_item(input logic [orb_pkg::FUNC_W-1:0] func,
			input logic [orb_pkg::BYTE_W-1:0] data, input logic [orb_pkg::BURST_W-1:0] req);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(orb_pkg::IN_DATA_W - orb_pkg::IN_BITS){1'b0}}, req, data};
		s_axis_tuser  <= func;
		do @(posedge clk); while (!s_axis_tready);
		predict_ring(func, data, req);
		case (func)
			orb_pkg::FUNC_PUSH:  pushes_sent++;
			orb_pkg::FUNC_READ:  reads_sent++;
			orb_pkg::FUNC_FLUSH: flushes_sent++;
			default:             stats_sent++;
		endcase
	endtask

	// Stop offering, then wait until every expected result has been seen.
	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Empty ring, zero and saturated burst sizes, flush, and byte extremes.
	task automatic test_basic_ops();
		send_item(orb_pkg::FUNC_STATS, 8'h00, 7'd0);
		send_item(orb_pkg::FUNC_READ, 8'hFF, 7'd5);
		send_item(orb_pkg::FUNC_PUSH, 8'h00, 7'h7F);
		send_item(orb_pkg::FUNC_PUSH, 8'hFF, 7'h00);
		send_item(orb_pkg::FUNC_PUSH, 8'hA5, 7'h2A);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd0);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'h7F);
		send_item(orb_pkg::FUNC_PUSH, 8'h5A, 7'h55);
		send_item(orb_pkg::FUNC_PUSH, 8'hC3, 7'd1);
		send_item(orb_pkg::FUNC_FLUSH, 8'hFF, 7'h7F);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd1);
		send_item(orb_pkg::FUNC_STATS, 8'hFF, 7'h7F);
		send_item(orb_pkg::FUNC_PUSH, 8'h11, 7'd0);
		send_item(orb_pkg::FUNC_PUSH, 8'h22, 7'd0);
		send_item(orb_pkg::FUNC_PUSH, 8'h33, 7'd0);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd2);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd1);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd1);
		send_item(orb_pkg::FUNC_STATS, 8'h00, 7'd0);
	endtask

	// Bursts at and above the 64-byte cap; only the first finds enough data held, the rest are bounded by the fill.
	task automatic test_burst_limits();
		repeat (66) send_item(orb_pkg::FUNC_PUSH, 8'($urandom), 7'($urandom));
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd65);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd64);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd127);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd63);
		send_item(orb_pkg::FUNC_STATS, 8'h00, 7'd0);
	endtask

	// The receiver holds off for a long stretch while reads keep coming.
	task automatic test_backpressure();
		repeat (8) send_item(orb_pkg::FUNC_PUSH, 8'($urandom), 7'($urandom));
		hold_req++;
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd3);
		send_item(orb_pkg::FUNC_STATS, 8'h00, 7'd0);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd2);
		send_item(orb_pkg::FUNC_PUSH, 8'h77, 7'd0);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd64);
		send_item(orb_pkg::FUNC_READ, 8'h00, 7'd4);
		wait_for_results();
	endtask

	// Mostly runs of pushes followed by reads, with flushes and queries mixed in.
	task automatic test_random(input int unsigned n_items);
		int unsigned sent;
		int unsigned pick;
		int unsigned run_len;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				run_len = $urandom_range(1, 12);
				repeat (run_len)
					send_item(orb_pkg::FUNC_PUSH, 8'($urandom), 7'($urandom));
				sent += run_len;
			end else if (pick < 80) begin
				if ($urandom_range(3) == 0)
					send_item(orb_pkg::FUNC_READ, 8'($urandom), 7'($urandom));
				else
					send_item(orb_pkg::FUNC_READ, 8'($urandom), 7'($urandom_range(1, 16)));
				sent++;
			end else if (pick < 92) begin
				send_item(orb_pkg::FUNC_STATS, 8'($urandom), 7'($urandom));
				sent++;
			end else begin
				send_item(orb_pkg::FUNC_FLUSH, 8'($urandom), 7'($urandom));
				sent++;
			end
		end
	endtask

	// Receiver: random stalls, or a long hold when one is requested.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen  = hold_req;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin : result_check
		ring_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				report_error("result transfer with no result expected");
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[orb_pkg::BYTE_W-1:0] !== want.out_byte)
					report_error($sformatf("out_byte %h, expected %h",
						m_axis_tdata[orb_pkg::BYTE_W-1:0], want.out_byte));
				if (m_axis_tuser[0] !== want.has_data)
					report_error($sformatf("has_data %b, expected %b",
						m_axis_tuser[0], want.has_data));
				if (m_axis_tlast !== want.last)
					report_error($sformatf("last %b, expected %b", m_axis_tlast, want.last));
				if (m_axis_tdata[HELD_LO +: orb_pkg::HELD_W] !== want.held_count)
					report_error($sformatf("held_count %0d, expected %0d",
						m_axis_tdata[HELD_LO +: orb_pkg::HELD_W], want.held_count));
				if (m_axis_tdata[RX_LO +: orb_pkg::CTR_W] !== want.rx_total)
					report_error($sformatf("rx_total %0d, expected %0d",
						m_axis_tdata[RX_LO +: orb_pkg::CTR_W], want.rx_total));
				if (m_axis_tdata[DROP_LO +: orb_pkg::CTR_W] !== want.drop_total)
					report_error($sformatf("drop_total %0d, expected %0d",
						m_axis_tdata[DROP_LO +: orb_pkg::CTR_W], want.drop_total));
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		s_axis_tuser    = orb_pkg::FUNC_PUSH;
		ring_head       = '0;
		ring_fill       = '0;
		rx_count        = '0;
		drop_count      = '0;
		hold_req        = 0;
		hold_seen       = 0;
		stall_left      = 0;
		cycle_count     = 0;
		error_count     = 0;
		results_checked = 0;
		pushes_sent     = 0;
		reads_sent      = 0;
		flushes_sent    = 0;
		stats_sent      = 0;
		set_idling(15, 76);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_burst_limits();
		test_backpressure();
		test_random(5);
		set_idling(76, 15);
		test_random(5);
		set_idling(0, 0);
		test_random(5);

		wait_for_results();

		$display("Covered %0d pushes (%0d overwritten), %0d reads, %0d flushes, %0d queries.",
			pushes_sent, drop_count, reads_sent, flushes_sent, stats_sent);
		$display("Checked %0d results under swapped, long and absent stalls on both sides.",
			results_checked);
		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/orb_pkg.sv
hw/rtl/orb_ram.sv
hw/rtl/overwrite_oldest_byte_ring_top.sv
tb/sv/tb.sv
